// ===== design/vtn_pkg.sv =====
`timescale 1ns / 1ps
package vtn_pkg;

  // coefficient format and derived widths
  localparam int CW        = 16;
  localparam int COF_SHIFT = (2 * CW > 32) ? 2 * CW - 32 : 0;
  localparam int COFW      = 2 * CW + 1;
  localparam int DW        = CW + COFW + 2;
  localparam int NMW       = 32;
  localparam int AW        = CW + 19;
  localparam int NPW       = NMW + 16;
  localparam int VW        = NPW + 2;
  localparam int NG        = (VW + 7) / 8;
  localparam int GW        = $clog2(NG);
  localparam int RW        = 16;
  localparam int RSW       = 2 * RW;
  localparam int L2W       = 2 * RW + 2;
  localparam int UW        = 16;
  localparam int UNIT_SH   = 30;
  localparam int FRONT_DEPTH = 5;

  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;

  localparam logic [63:0] ROW_X_RST = 64'd4096;
  localparam logic [63:0] ROW_Y_RST = 64'd1 << 28;
  localparam logic [63:0] ROW_Z_RST = 64'd1 << 44;
  localparam logic [NMW-1:0] NM_ONE = NMW'((64'd1 << 24) >> COF_SHIFT);

  typedef enum logic [1:0] {CF_IDLE, CF_COF, CF_DET, CF_SIGN} cf_state_t;

  typedef logic [2:0][63:0] rows_t;
  typedef logic [2:0][2:0][NMW-1:0] nm_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [2:0]         neg;
    logic               degen;
  } side_t;

  // coefficient col of a row; bits past the top of the row read as zero
  function automatic logic signed [CW-1:0] coef_of(input logic [63:0] row, input int col);
    logic [63+CW:0] padded;
    padded = {{CW{1'b0}}, row};
    return padded[col*CW +: CW];
  endfunction

endpackage

// ===== design/vertex_transform_with_normals_top.sv =====
`timescale 1ns / 1ps
// Vertex transform with normal matrix.
// Input: one vertex per beat on in_pos_* (Q8.8) and in_norm_* (Q1.14), taken
// at a clock edge with start high and busy low. A new vertex may be given
// in every cycle; the pipeline has no stall.
// Output: out_valid is high for exactly one cycle with the transformed
// position (Q8.8, saturated), the unit normal (Q1.14) and
// out_normal_degenerate. Results appear on the ports in order, one result
// per vertex. Sustained rate is one vertex per clock while busy is low; the
// depth is set by the five transform/reduce stages, the sixteen one-bit
// stages of the normalization search and the output register.
// Configuration: APB port, three 64-bit matrix rows at byte address 8*i.
// After a row write the normal matrix is rebuilt by a shared cofactor unit;
// busy is high meanwhile and no vertex is taken.
// Reset (rst_n low, synchronous) loads the identity matrix and empties the
// pipeline. The receiver cannot stall, so results are never held.
module vertex_transform_with_normals_top import vtn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output logic               out_valid,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic               out_normal_degenerate
);

  localparam int VD = FRONT_DEPTH + UW;

  rows_t rows;
  nm_t   nm;
  side_t fr_side;
  logic [RSW-1:0] r_sq [0:2];
  logic [L2W-1:0] len2;
  logic [UW-1:0]  u [0:2];

  logic  vld_r [0:VD-1];
  side_t sd_r  [0:UW-1];

  logic        out_valid_r;
  side_t       out_sd_r;
  logic signed [15:0] onorm_r [0:2];
  logic [UW:0]        qsum [0:2];
  logic signed [15:0] qv   [0:2];

  vtn_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .rows(rows), .nm(nm), .busy(busy)
  );

  vtn_front u_front (
    .clk(clk),
    .pos_x(in_pos_x), .pos_y(in_pos_y), .pos_z(in_pos_z),
    .norm_x(in_norm_x), .norm_y(in_norm_y), .norm_z(in_norm_z),
    .rows(rows), .nm(nm), .side(fr_side), .r_sq(r_sq), .len2(len2)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vtn_sqrt_lane u_lane (.clk(clk), .r_sq(r_sq[i]), .len2(len2), .u(u[i]));
  end

  // valid bits for every stage of the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < VD; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k < VD; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[VD-1];
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= fr_side;
    for (int k = 1; k < UW; k++) sd_r[k] <= sd_r[k-1];
  end

  // q = (u + 1) / 2, then sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qsum[i] = {1'b0, u[i]} + (UW+1)'(1);
      if (sd_r[UW-1].degen)        qv[i] = '0;
      else if (sd_r[UW-1].neg[i])  qv[i] = -$signed(qsum[i][16:1]);
      else                         qv[i] = $signed(qsum[i][16:1]);
    end
  end

  always_ff @(posedge clk) begin
    out_sd_r <= sd_r[UW-1];
    for (int i = 0; i < 3; i++) onorm_r[i] <= qv[i];
  end

  assign out_valid             = out_valid_r;
  assign out_pos_x             = out_sd_r.px;
  assign out_pos_y             = out_sd_r.py;
  assign out_pos_z             = out_sd_r.pz;
  assign out_norm_x            = onorm_r[0];
  assign out_norm_y            = onorm_r[1];
  assign out_norm_z            = onorm_r[2];
  assign out_normal_degenerate = out_sd_r.degen;

endmodule

// ===== design/vtn_cfg.sv =====
`timescale 1ns / 1ps
module vtn_cfg import vtn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output rows_t       rows,
  output nm_t         nm,
  output logic        busy
);

  rows_t rows_r;
  nm_t   nm_r;
  cf_state_t st_r, st_nxt;
  logic [1:0] ci_r, cj_r, ci_nxt, cj_nxt;
  logic signed [COFW-1:0] cof_r [0:2][0:2];
  logic signed [DW-1:0] det_r;
  logic cof_we, det_we, nm_we, det_clr;

  logic [1:0] widx;
  logic wr_ok;
  logic [1:0] i1, i2, j1, j2;
  logic signed [2*CW-1:0] m1, m2;
  logic signed [COFW-1:0] cofv;
  logic signed [CW+COFW-1:0] dprod;
  logic signed [COFW-1:0] csh;
  logic signed [63:0] s64, sv;
  logic [NMW-1:0] nmv;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic signed [CW-1:0] ac(input logic [1:0] i, input logic [1:0] j);
    return coef_of(rows_r[i], int'(j));
  endfunction

  assign widx  = paddr[4:3];
  assign wr_ok = psel && penable && pwrite &&
                 (widx == REG_ROW_X || widx == REG_ROW_Y || widx == REG_ROW_Z);
  assign pready = 1'b1;
  assign rows   = rows_r;
  assign nm     = nm_r;

  always_comb begin
    unique case (widx)
      REG_ROW_X: prdata = rows_r[0];
      REG_ROW_Y: prdata = rows_r[1];
      REG_ROW_Z: prdata = rows_r[2];
      default:   prdata = '0;
    endcase
  end

  // next state; a row write always restarts the rebuild from the first cofactor
  always_comb begin
    st_nxt = st_r;
    ci_nxt = ci_r;
    cj_nxt = cj_r;
    if (wr_ok) begin
      st_nxt = CF_COF;
      ci_nxt = 2'd0;
      cj_nxt = 2'd0;
    end else begin
      unique case (st_r)
        CF_IDLE: begin
          st_nxt = CF_IDLE;
        end
        CF_COF, CF_SIGN: begin
          if (cj_r == 2'd2) begin
            cj_nxt = 2'd0;
            if (ci_r == 2'd2) begin
              ci_nxt = 2'd0;
              st_nxt = (st_r == CF_COF) ? CF_DET : CF_IDLE;
            end else begin
              ci_nxt = ci_r + 2'd1;
            end
          end else begin
            cj_nxt = cj_r + 2'd1;
          end
        end
        CF_DET: begin
          if (cj_r == 2'd2) begin
            cj_nxt = 2'd0;
            st_nxt = CF_SIGN;
          end else begin
            cj_nxt = cj_r + 2'd1;
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    busy    = (st_r != CF_IDLE);
    cof_we  = (st_r == CF_COF);
    det_we  = (st_r == CF_DET);
    nm_we   = (st_r == CF_SIGN);
    det_clr = (st_r == CF_IDLE) || (st_r == CF_COF);
  end

  always_comb begin
    i1 = inc3(ci_r);
    i2 = inc3(i1);
    j1 = inc3(cj_r);
    j2 = inc3(j1);
    m1 = ac(i1, j1) * ac(i2, j2);
    m2 = ac(i1, j2) * ac(i2, j1);
    cofv = COFW'(m1) - COFW'(m2);
    dprod = ac(2'd0, cj_r) * cof_r[0][cj_r];
    csh = cof_r[ci_r][cj_r] >>> COF_SHIFT;
    s64 = 64'(csh);
    if (det_r < 0)      sv = -s64;
    else if (det_r > 0) sv = s64;
    else                sv = '0;
    if (sv > 64'sd2147483647)       nmv = 32'h7fff_ffff;
    else if (sv < -64'sd2147483648) nmv = 32'h8000_0000;
    else                            nmv = sv[NMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CF_IDLE;
      ci_r <= '0;
      cj_r <= '0;
      rows_r[0] <= ROW_X_RST;
      rows_r[1] <= ROW_Y_RST;
      rows_r[2] <= ROW_Z_RST;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          nm_r[i][j] <= (i == j) ? NM_ONE : '0;
        end
      end
    end else begin
      st_r <= st_nxt;
      ci_r <= ci_nxt;
      cj_r <= cj_nxt;
      if (wr_ok) rows_r[widx] <= pwdata;
      if (nm_we) nm_r[ci_r][cj_r] <= nmv;
    end
  end

  always_ff @(posedge clk) begin
    if (cof_we) cof_r[ci_r][cj_r] <= cofv;
    if (det_clr)     det_r <= '0;
    else if (det_we) det_r <= det_r + DW'(dprod);
  end

endmodule

// ===== design/vtn_front.sv =====
`timescale 1ns / 1ps
module vtn_front import vtn_pkg::*; (
  input  logic               clk,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  rows_t              rows,
  input  nm_t                nm,
  output side_t              side,
  output logic [RSW-1:0]     r_sq [0:2],
  output logic [L2W-1:0]     len2
);

  logic signed [15:0] p [0:2];
  logic signed [15:0] n [0:2];

  logic signed [CW+15:0] pp_r [0:2][0:2];
  logic signed [NPW-1:0] np_r [0:2][0:2];

  logic signed [AW-1:0] acc [0:2];
  logic signed [AW-1:0] sh  [0:2];
  logic signed [15:0]   pq  [0:2];
  logic signed [VW-1:0] v   [0:2];
  logic [VW-1:0]        mg  [0:2];
  logic [2:0]           ng;

  logic signed [15:0] pos2_r [0:2];
  logic [2:0]         neg2_r;
  logic [VW-1:0]      mag2_r [0:2];

  logic [NG*8-1:0] orm3;
  logic [GW-1:0]   grp;
  logic            nz;
  logic signed [15:0] pos3_r [0:2];
  logic [2:0]         neg3_r;
  logic [VW-1:0]      mag3_r [0:2];
  logic [GW-1:0]      grp3_r;
  logic               nz3_r;

  logic [NG*8-1:0] orm4;
  logic [7:0]      byt;
  logic [2:0]      bp;
  logic [GW+2:0]   msb, shv;
  logic [RW-1:0]   rv [0:2];
  side_t           sd4_r;
  logic [RW-1:0]   rv4_r [0:2];

  side_t           sd5_r;
  logic [RSW-1:0]  rsq5_r [0:2];
  logic [L2W-1:0]  len2_5_r;

  assign p[0] = pos_x;
  assign p[1] = pos_y;
  assign p[2] = pos_z;
  assign n[0] = norm_x;
  assign n[1] = norm_y;
  assign n[2] = norm_z;

  // stage 1: products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_r[i][j] <= coef_of(rows[i], j) * p[j];
        np_r[i][j] <= $signed(nm[i][j]) * n[j];
      end
    end
  end

  // stage 2: sums, position rounding and saturation, normal magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(pp_r[i][0]) + AW'(pp_r[i][1]) + AW'(pp_r[i][2])
             + (AW'(coef_of(rows[i], 3)) <<< 8) + AW'(2048);
      sh[i] = acc[i] >>> 12;
      if (sh[i] > AW'(32767))       pq[i] = 16'sh7fff;
      else if (sh[i] < AW'(-32768)) pq[i] = -16'sh8000;
      else                          pq[i] = sh[i][15:0];
      v[i] = VW'(np_r[i][0]) + VW'(np_r[i][1]) + VW'(np_r[i][2]);
      ng[i] = v[i][VW-1];
      mg[i] = ng[i] ? VW'(-v[i]) : VW'(v[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pos2_r[i] <= pq[i];
      mag2_r[i] <= mg[i];
    end
    neg2_r <= ng;
  end

  // stage 3: coarse leading-one search by byte
  always_comb begin
    orm3 = (NG*8)'(mag2_r[0] | mag2_r[1] | mag2_r[2]);
    grp = '0;
    nz = 1'b0;
    for (int g = 0; g < NG; g++) begin
      if (|orm3[g*8 +: 8]) begin
        grp = GW'(g);
        nz = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pos3_r[i] <= pos2_r[i];
      mag3_r[i] <= mag2_r[i];
    end
    neg3_r <= neg2_r;
    grp3_r <= grp;
    nz3_r <= nz;
  end

  // stage 4: fine search within the byte, common shift to 16 bits
  always_comb begin
    orm4 = (NG*8)'(mag3_r[0] | mag3_r[1] | mag3_r[2]);
    byt = orm4[grp3_r*8 +: 8];
    bp = '0;
    for (int b = 0; b < 8; b++) begin
      if (byt[b]) bp = 3'(b);
    end
    msb = {grp3_r, bp};
    shv = (msb > (GW+3)'(15)) ? msb - (GW+3)'(15) : '0;
    for (int i = 0; i < 3; i++) begin
      rv[i] = RW'(mag3_r[i] >> shv);
    end
  end

  always_ff @(posedge clk) begin
    sd4_r.px <= pos3_r[0];
    sd4_r.py <= pos3_r[1];
    sd4_r.pz <= pos3_r[2];
    sd4_r.neg <= neg3_r;
    sd4_r.degen <= !nz3_r;
    for (int i = 0; i < 3; i++) rv4_r[i] <= rv[i];
  end

  // stage 5: squares and squared length
  always_ff @(posedge clk) begin
    sd5_r <= sd4_r;
    for (int i = 0; i < 3; i++) rsq5_r[i] <= rv4_r[i] * rv4_r[i];
    len2_5_r <= L2W'(rv4_r[0] * rv4_r[0]) + L2W'(rv4_r[1] * rv4_r[1])
              + L2W'(rv4_r[2] * rv4_r[2]);
  end

  assign side = sd5_r;
  assign r_sq = rsq5_r;
  assign len2 = len2_5_r;

endmodule

// ===== design/vtn_sqrt_lane.sv =====
`timescale 1ns / 1ps
module vtn_sqrt_lane import vtn_pkg::*; (
  input  logic           clk,
  input  logic [RSW-1:0] r_sq,
  input  logic [L2W-1:0] len2,
  output logic [UW-1:0]  u
);

  // largest u with u*u*len2 <= r_sq << UNIT_SH, one bit per stage;
  // p tracks u*u*len2 and a tracks u*len2 so each step is shifts and adds
  localparam int PW = 2 * UW + L2W + 2;
  localparam int QW = UW + L2W + 1;

  logic [PW-1:0]  p_r [0:UW-1];
  logic [QW-1:0]  a_r [0:UW-1];
  logic [L2W-1:0] l_r [0:UW-1];
  logic [PW-1:0]  t_r [0:UW-1];
  logic [UW-1:0]  u_r [0:UW-1];

  for (genvar s = 0; s < UW; s++) begin : g_stage
    localparam int K = UW - 1 - s;
    logic [PW-1:0]  p_in, t_in, cand;
    logic [QW-1:0]  a_in;
    logic [L2W-1:0] l_in;
    logic [UW-1:0]  u_in;

    if (s == 0) begin : g_first
      assign p_in = '0;
      assign a_in = '0;
      assign l_in = len2;
      assign t_in = PW'(r_sq) << UNIT_SH;
      assign u_in = '0;
    end else begin : g_next
      assign p_in = p_r[s-1];
      assign a_in = a_r[s-1];
      assign l_in = l_r[s-1];
      assign t_in = t_r[s-1];
      assign u_in = u_r[s-1];
    end

    assign cand = p_in + (PW'(a_in) << (K + 1)) + (PW'(l_in) << (2 * K));

    always_ff @(posedge clk) begin
      l_r[s] <= l_in;
      t_r[s] <= t_in;
      if (cand <= t_in) begin
        p_r[s] <= cand;
        a_r[s] <= a_in + (QW'(l_in) << K);
        u_r[s] <= u_in | (UW'(1) << K);
      end else begin
        p_r[s] <= p_in;
        a_r[s] <= a_in;
        u_r[s] <= u_in;
      end
    end
  end

  assign u = u_r[UW-1];

endmodule

// ===== test/vertex_transform_with_normals_top_test.sv =====
`timescale 1ns / 1ps
module vertex_transform_with_normals_top_test;
  import vtn_pkg::*;

  localparam int DRAIN = 32;
  localparam int LIMIT = 300000;
  localparam logic [4:0] ADDR_UNUSED = 5'd24;

  typedef struct {
    bit          wr;
    logic [4:0]  addr;
    logic [63:0] data;
    logic [15:0] px, py, pz, nx, ny, nz;
  } vtx_op_t;

  typedef struct {
    logic [15:0] px, py, pz, nx, ny, nz;
    logic        degen;
  } xform_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_norm_x = '0, in_norm_y = '0, in_norm_z = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready, busy, out_valid, out_normal_degenerate;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z;

  vertex_transform_with_normals_top uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vtx_op_t pending_ops[$];
  xform_t  xform_q[$];
  vtx_op_t cur_vtx;
  logic [63:0] mrow[3];
  longint nmat[9];
  int errors = 0, vertices = 0, row_writes = 0, degen_seen = 0, cycles = 0;
  int hold = 0, quiet = 0;

  task automatic queue_op(vtx_op_t op);
    pending_ops = {pending_ops, op};
  endtask

  task automatic queue_expect(xform_t x);
    xform_q = {xform_q, x};
  endtask

  function automatic longint coef_at(int r, int col);
    logic [63:0] sh;
    logic [CW-1:0] c;
    if (col * CW >= 64) return 0;
    sh = mrow[r] >> (col * CW);
    c = sh[CW-1:0];
    return longint'($signed(c));
  endfunction

  task automatic rebuild_cofactors();
    longint a[3][3], c[3][3], det, v;
    int sg;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = coef_at(i, j);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        c[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
    det = a[0][0] * c[0][0] + a[0][1] * c[0][1] + a[0][2] * c[0][2];
    sg = det > 0 ? 1 : (det < 0 ? -1 : 0);
    for (int k = 0; k < 9; k++) begin
      v = (c[k/3][k%3] >>> COF_SHIFT) * sg;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      nmat[k] = v;
    end
  endtask

  // binary search for round-half-up of r*16384/sqrt(len2), 64-bit wrapping math
  function automatic logic [15:0] unit_part(bit [63:0] r, bit [63:0] len2);
    bit [63:0] rhs, lo, hi, mid, t;
    rhs = (r << 15) * (r << 15);
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      if (t * t * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic xform_t transform_vertex(vtx_op_t op);
    xform_t x;
    longint p[3], n[3], v[3], acc;
    bit [63:0] mag[3], r[3], len2;
    logic [15:0] q[3], u;
    int s;
    p[0] = $signed(op.px); p[1] = $signed(op.py); p[2] = $signed(op.pz);
    n[0] = $signed(op.nx); n[1] = $signed(op.ny); n[2] = $signed(op.nz);
    for (int i = 0; i < 3; i++) begin
      acc = coef_at(i, 0) * p[0] + coef_at(i, 1) * p[1] + coef_at(i, 2) * p[2]
          + coef_at(i, 3) * 256;
      acc = (acc + 2048) >>> 12;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      q[i] = acc[15:0];
      v[i] = nmat[i*3] * n[0] + nmat[i*3+1] * n[1] + nmat[i*3+2] * n[2];
      mag[i] = v[i] < 0 ? -v[i] : v[i];
    end
    x.px = q[0]; x.py = q[1]; x.pz = q[2];
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
      x.nx = '0; x.ny = '0; x.nz = '0; x.degen = 1'b1;
      return x;
    end
    s = 0;
    while ((mag[0] >> s) >= 65536 || (mag[1] >> s) >= 65536 || (mag[2] >> s) >= 65536) s++;
    for (int i = 0; i < 3; i++) r[i] = mag[i] >> s;
    len2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
    for (int i = 0; i < 3; i++) begin
      u = unit_part(r[i], len2);
      q[i] = v[i] < 0 ? -u : u;
    end
    x.nx = q[0]; x.ny = q[1]; x.nz = q[2];
    x.degen = 1'b0;
    return x;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pack_row(int c0, int c1, int c2, int c3);
    logic [15:0] a, b, c, d;
    a = 16'(c0); b = 16'(c1); c = 16'(c2); d = 16'(c3);
    return {d, c, b, a};
  endfunction

  function automatic vtx_op_t mk_vtx(int px, int py, int pz, int nx, int ny, int nz);
    vtx_op_t op;
    op.wr = 0; op.addr = '0; op.data = '0;
    op.px = 16'(px); op.py = 16'(py); op.pz = 16'(pz);
    op.nx = 16'(nx); op.ny = 16'(ny); op.nz = 16'(nz);
    return op;
  endfunction

  function automatic vtx_op_t rand_vtx();
    vtx_op_t op;
    int k;
    op = mk_vtx($urandom, $urandom, $urandom, 0, 0, 0);
    if ($urandom_range(0, 9) == 0) op.px = 16'($urandom_range(0, 600) - 300);
    k = $urandom_range(0, 99);
    if (k < 65) begin
      op.nx = 16'($urandom_range(0, 32768) - 16384);
      op.ny = 16'($urandom_range(0, 32768) - 16384);
      op.nz = 16'($urandom_range(0, 32768) - 16384);
    end else if (k < 90) begin
      op.nx = 16'($urandom); op.ny = 16'($urandom); op.nz = 16'($urandom);
    end else if (k < 95) begin
      op.nx = 16'($urandom_range(0, 4) - 2); op.ny = 16'($urandom_range(0, 4) - 2);
      op.nz = 16'($urandom_range(0, 4) - 2);
    end
    return op;
  endfunction

  task automatic push_write(logic [4:0] addr, logic [63:0] data);
    vtx_op_t op;
    op = mk_vtx(0, 0, 0, 0, 0, 0);
    op.wr = 1; op.addr = addr; op.data = data;
    queue_op(op);
  endtask

  task automatic push_matrix(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz, int n);
    push_write({REG_ROW_X, 3'b000}, rx);
    push_write({REG_ROW_Y, 3'b000}, ry);
    push_write({REG_ROW_Z, 3'b000}, rz);
    for (int i = 0; i < n; i++) queue_op(rand_vtx());
  endtask

  // driver: one vertex or register write at a time
  always @(posedge clk) begin
    vtx_op_t op;
    bit ns;
    int hn, idx;
    ns = start;
    hn = hold;
    if (!rst_n) begin
      ns = 1'b0;
    end else begin
      if (start && !busy) begin
        queue_expect(transform_vertex(cur_vtx));
        vertices++;
        ns = 1'b0;
        hn = pick_gap();
      end
      if (xform_q.size() != 0 || ns) quiet <= 0;
      else quiet <= quiet + 1;
      if (psel) begin
        if (penable) begin
          if (pready) begin
            idx = int'(paddr[4:3]);
            if (idx < 3) begin
              mrow[idx] = pwdata;
              rebuild_cofactors();
            end
            row_writes++;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            hn = pick_gap() + 2;
          end
        end else begin
          penable <= 1'b1;
        end
      end else if (ns) begin
        // waiting for busy to drop
      end else if (hn > 0) begin
        hn = hn - 1;
      end else if (pending_ops.size() != 0) begin
        if (pending_ops[0].wr) begin
          if (xform_q.size() == 0 && quiet >= DRAIN) begin
            op = pending_ops.pop_front();
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= op.addr;
            pwdata <= op.data;
          end
        end else begin
          op = pending_ops.pop_front();
          cur_vtx = op;
          ns = 1'b1;
          in_pos_x <= op.px; in_pos_y <= op.py; in_pos_z <= op.pz;
          in_norm_x <= op.nx; in_norm_y <= op.ny; in_norm_z <= op.nz;
        end
      end
    end
    start <= ns;
    hold <= hn;
  end

  task automatic check_field(string name, logic [15:0] expv, logic [15:0] act);
    if (expv !== act) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, $signed(expv), $signed(act));
    end
  endtask

  // monitor: every strobed beat is one result
  always @(posedge clk) begin
    xform_t e;
    if (rst_n && out_valid) begin
      if (xform_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none got pos %0d",
                 $time, out_pos_x);
      end else begin
        e = xform_q.pop_front();
        check_field("out_pos_x", e.px, out_pos_x);
        check_field("out_pos_y", e.py, out_pos_y);
        check_field("out_pos_z", e.pz, out_pos_z);
        check_field("out_norm_x", e.nx, out_norm_x);
        check_field("out_norm_y", e.ny, out_norm_y);
        check_field("out_norm_z", e.nz, out_norm_z);
        check_field("out_normal_degenerate", 16'(e.degen), 16'(out_normal_degenerate));
        if (e.degen) degen_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, xform_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mrow[0] = ROW_X_RST;
    mrow[1] = ROW_Y_RST;
    mrow[2] = ROW_Z_RST;
    rebuild_cofactors();
    // directed, reset matrix
    queue_op(mk_vtx(32767, 32767, 32767, 16384, 0, 0));
    queue_op(mk_vtx(-32768, -32768, -32768, -16384, 0, 0));
    queue_op(mk_vtx(0, 0, 0, 0, 0, 0));
    queue_op(mk_vtx(1, -1, 256, 0, 16384, 0));
    queue_op(mk_vtx(-1, 255, -256, 0, 0, -16384));
    queue_op(mk_vtx(100, 200, 300, 11585, 11585, 0));
    queue_op(mk_vtx(0, 0, 0, 1, 0, 0));
    queue_op(mk_vtx(0, 0, 0, -32768, 32767, -32768));
    queue_op(mk_vtx(0, 0, 0, 32767, 32767, 32767));
    queue_op(mk_vtx(0, 0, 0, 1, 1, 1));
    queue_op(mk_vtx(0, 0, 0, -1, 2, -3));
    // translation plus half-up rounding, then saturation
    push_matrix(pack_row(4096, 0, 0, 2048), pack_row(2048, 4096, 0, -2048),
                pack_row(0, 0, 4096, 32767), 0);
    queue_op(mk_vtx(1, 1, 32767, 9000, -9000, 100));
    queue_op(mk_vtx(-32768, 32767, -1, 0, 0, 0));
    queue_op(mk_vtx(3, -3, 0, 16384, 16384, 16384));
    // mirror: negative determinant
    push_matrix(pack_row(-4096, 0, 0, -32768), pack_row(0, 4096, 0, 0),
                pack_row(0, 0, 4096, 0), 240);
    // singular: all normals degenerate
    push_matrix(pack_row(0, 0, 0, 0), pack_row(0, 0, 0, 0), pack_row(0, 0, 0, 0), 240);
    push_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, 60);
    push_matrix({4{16'h8000}}, pack_row(32767, -32768, 32767, 0),
                pack_row(-32768, -32768, 32767, -32768), 200);
    push_matrix(pack_row(32767, 0, 0, 1), pack_row(0, -32768, 0, -1),
                pack_row(0, 0, 32767, 0), 200);
    for (int ph = 0; ph < 4; ph++)
      push_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 150);
    for (int ph = 0; ph < 3; ph++)
      push_matrix(pack_row($urandom_range(1024, 8192) * (ph == 1 ? -1 : 1),
                           $urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
                           $urandom_range(0, 65535)),
                  pack_row($urandom_range(0, 2048) - 1024, $urandom_range(1024, 8192),
                           $urandom_range(0, 2048) - 1024, $urandom_range(0, 65535)),
                  pack_row($urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
                           $urandom_range(1024, 8192), $urandom_range(0, 65535)), 140);
    // write to the unused slot must leave the matrix alone
    push_write(ADDR_UNUSED, {$urandom, $urandom});
    for (int i = 0; i < 100; i++) queue_op(rand_vtx());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_ops.size() != 0 || start || psel || xform_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("%0d vertices over %0d register writes, %0d degenerate normals, %0d cycles",
             vertices, row_writes, degen_seen, cycles);
    if (errors == 0 && xform_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
